FILE: hdl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg - shared types and constants for the LRU key-value cache
// Fixed field widths, the capacity register reset, the miss value, the op codes and the scan-unit controls.
// ----------------------------------------------------------------------------
package lkv_pkg;

	// widths of the key, value and read_value ports
	localparam int DATA_BITS = 32;
	typedef logic [DATA_BITS-1:0] data_t;

	// capacity register
	localparam int CAP_BITS = 5;
	typedef logic [CAP_BITS-1:0] cap_t;
	localparam cap_t CAP_RESET = cap_t'(16);

	// read_value returned on a miss (all ones, i.e. -1)
	localparam data_t MISS_VALUE = '1;

	// operation codes on the kind input
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	// controls from the sequencer to the scan unit
	typedef struct packed {
		logic clear;   // start of a new search
		logic sample;  // read data for one entry is on the RAM output
	} scan_ctl_t;

endpackage

FILE: hdl/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: hdl/lkv_scan.sv
// ----------------------------------------------------------------------------
// lkv_scan - key search over the entry stream
// Takes one entry per sample, remembers the first key match and the
// entry holding the oldest rank.
// ----------------------------------------------------------------------------
module lkv_scan #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lkv_pkg::scan_ctl_t    ctl,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [IW-1:0]         last_rank,
	input  logic [IW-1:0]         idx,
	input  logic [KEY_BITS-1:0]   rd_key,
	input  logic [VALUE_BITS-1:0] rd_value,
	input  logic [IW-1:0]         rd_rank,
	output logic                  found,
	output logic [IW-1:0]         match_idx,
	output logic [IW-1:0]         match_rank,
	output logic [VALUE_BITS-1:0] match_value,
	output logic [IW-1:0]         oldest_idx
);

	logic found_q;
	logic is_match;

	assign is_match = ctl.sample && !found_q && (rd_key == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (is_match) begin
			found_q <= 1'b1;
		end
	end

	// ranks of valid entries are a permutation, so the oldest holds last_rank
	always_ff @(posedge clk) begin
		if (is_match) begin
			match_idx   <= idx;
			match_rank  <= rd_rank;
			match_value <= rd_value;
		end
		if (ctl.sample && rd_rank == last_rank) begin
			oldest_idx <= idx;
		end
	end

	assign found = found_q;

endmodule

FILE: hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache - fully associative get/put store with LRU replacement
// Entries (key, value, recency rank) live in one RAM; a sequencer searches
// it entry by entry, then ages the ranks in a read-modify-write pass.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): kind selects get (0) or put (1),
//   key is looked up or stored, value is stored by a put.
//   Output channel (out_valid / out_stall): one transaction per get, with
//   hit and read_value (stored value on hit, all ones on a miss). A put
//   returns nothing.
//   Configuration channel (cfg_valid / cfg_ready): cfg_data sets capacity;
//   0 acts as 1, values above ENTRIES act as ENTRIES. Write it while idle.
// Sequence, with n valid entries:
//   accept, a search read of each valid entry (one RAM read port), drain and decide,
//   then an aging read of each entry unless the touched entry was already most
//   recent, no other entry is valid, or the get missed. An empty cache goes from
//   accept straight to decide (no search, no drain). in_stall is low only
//   between transactions.
// Reset: valid entries are the low count_q addresses, so clearing the count
//   empties the cache; no RAM clearing pass. Capacity resets to 16.
// Stall: a result waits in the output register. The next transaction is
//   taken and searched; a get then holds in decide until the register frees.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// request
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    kind,
	input  logic signed [lkv_pkg::DATA_BITS-1:0]    key,
	input  logic signed [lkv_pkg::DATA_BITS-1:0]    value,
	// response
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    hit,
	output logic signed [lkv_pkg::DATA_BITS-1:0]    read_value,
	// capacity register
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [lkv_pkg::CAP_BITS-1:0]            cfg_data
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;   // index / rank
	localparam int CW = $clog2(ENTRIES + 1);                   // count
	localparam int EW = (CW > lkv_pkg::CAP_BITS) ? CW : lkv_pkg::CAP_BITS;
	localparam int WW = KEY_BITS + VALUE_BITS + IW;            // RAM word

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_UPDATE = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	lkv_pkg::cap_t         cap_q;
	logic [IW-1:0]         addr_q;
	logic [IW-1:0]         last_q;
	logic [IW-1:0]         slot_q;
	logic [CW-1:0]         limit_q;
	logic                  kind_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  out_valid_q;
	logic                  hit_q;
	lkv_pkg::data_t        read_value_q;

	// RAM read pipeline
	logic                  rd_v_s1;
	logic                  rd_upd_s1;
	logic [IW-1:0]         rd_idx_s1;

	logic                  in_accept;
	logic                  cfg_write;
	logic                  out_free;
	logic                  dec_go;
	logic                  dec_write;
	logic                  dec_fill;
	logic                  out_load;
	logic                  full;
	logic [EW-1:0]         eff_cap;
	logic [IW-1:0]         dec_slot;
	logic [CW-1:0]         dec_limit;
	logic [VALUE_BITS-1:0] dec_value;

	logic                  wb_en;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [WW-1:0]         wr_data;
	logic [WW-1:0]         rd_data;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_value;
	logic [IW-1:0]         rd_rank;

	lkv_pkg::scan_ctl_t    scan_ctl;
	logic                  found;
	logic [IW-1:0]         match_idx;
	logic [IW-1:0]         match_rank;
	logic [VALUE_BITS-1:0] match_value;
	logic [IW-1:0]         oldest_idx;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	assign {rd_key, rd_value, rd_rank} = rd_data;

	// ---- entry storage ----
	lkv_ram #(
		.WIDTH (WW),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// ---- search ----
	assign scan_ctl.clear  = in_accept;
	assign scan_ctl.sample = rd_v_s1 && !rd_upd_s1;

	lkv_scan #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.key         (key_q),
		.last_rank   (last_q),
		.idx         (rd_idx_s1),
		.rd_key      (rd_key),
		.rd_value    (rd_value),
		.rd_rank     (rd_rank),
		.found       (found),
		.match_idx   (match_idx),
		.match_rank  (match_rank),
		.match_value (match_value),
		.oldest_idx  (oldest_idx)
	);

	// ---- decision after the search ----
	always_comb begin
		eff_cap = EW'(cap_q);
		if (cap_q == '0) begin
			eff_cap = EW'(1);
		end else if (EW'(cap_q) > EW'(ENTRIES)) begin
			eff_cap = EW'(ENTRIES);
		end
	end

	assign full     = EW'(count_q) >= eff_cap;
	assign out_free = !out_valid_q || !out_stall;
	assign dec_go   = (state_q == ST_DECIDE) && (kind_q == lkv_pkg::KIND_PUT || out_free);
	assign out_load = dec_go && (kind_q == lkv_pkg::KIND_GET);
	// a get miss touches nothing
	assign dec_write = dec_go && (kind_q == lkv_pkg::KIND_PUT || found);
	assign dec_fill  = dec_go && (kind_q == lkv_pkg::KIND_PUT) && !found && !full;

	always_comb begin
		if (found) begin
			dec_slot  = match_idx;
			dec_limit = CW'(match_rank);
		end else if (full) begin
			// evict the oldest; every other entry ages
			dec_slot  = oldest_idx;
			dec_limit = CW'(count_q - CW'(1));
		end else begin
			// fill the next free entry; every valid entry ages
			dec_slot  = IW'(count_q);
			dec_limit = count_q;
		end
		dec_value = (kind_q == lkv_pkg::KIND_GET) ? match_value : value_q;
	end

	// ---- write port: slot write in decide, rank aging during the pass ----
	assign wb_en = rd_v_s1 && rd_upd_s1 && (rd_idx_s1 != slot_q)
		&& (CW'(rd_rank) < limit_q);
	assign wr_en = dec_write || wb_en;

	always_comb begin
		if (dec_write) begin
			wr_addr = dec_slot;
			wr_data = {key_q, dec_value, IW'(0)};
		end else begin
			wr_addr = rd_idx_s1;
			wr_data = {rd_key, rd_value, IW'(rd_rank + IW'(1))};
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			addr_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						addr_q  <= '0;
						state_q <= (count_q == '0) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= IW'(addr_q + IW'(1));
					if (addr_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (dec_go) begin
						addr_q <= '0;
						if (dec_fill) begin
							count_q <= CW'(count_q + CW'(1));
						end
						if (!dec_write || dec_limit == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_UPDATE: begin
					addr_q <= IW'(addr_q + IW'(1));
					// last write-back lands in the first idle cycle
					if (addr_q == last_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1   <= 1'b0;
			rd_upd_s1 <= 1'b0;
		end else begin
			rd_v_s1   <= (state_q == ST_SCAN) || (state_q == ST_UPDATE);
			rd_upd_s1 <= (state_q == ST_UPDATE);
		end
	end

	// transaction payload and per-item bookkeeping
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (in_accept) begin
			kind_q  <= kind;
			key_q   <= KEY_BITS'($unsigned(key));
			value_q <= VALUE_BITS'($unsigned(value));
			last_q  <= IW'(count_q - CW'(1));
		end
		if (dec_go) begin
			slot_q  <= dec_slot;
			limit_q <= dec_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_write) begin
			cap_q <= cfg_data;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q        <= found;
			read_value_q <= found ? lkv_pkg::data_t'(match_value) : lkv_pkg::MISS_VALUE;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	// ---- checks ----
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count above ENTRIES");

	a_count_only_decide: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q == ST_DECIDE))
		else $error("entry count changed outside decide");

	a_result_from_get: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DECIDE && kind_q == lkv_pkg::KIND_GET))
		else $error("result raised without a get");

	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN) |-> !wr_en)
		else $error("RAM written during key search");

endmodule
